### rtl/core/csvt_pkg.sv
// Shared types and constants of the CSV tokenizer.
package csvt_pkg;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_FILTER_ADDR = 3'd0;

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_CELL = 2'd1,
    KIND_ROW  = 2'd2,
    KIND_END  = 2'd3
  } kind_t;

  // Parser flags carried from one request to the next.
  typedef struct packed {
    logic quoted;
    logic quote_pending;
    logic in_comment;
    logic cell_nonempty;
    logic row_has_cells;
  } pstate_t;

  // Up to three results caused by one request, in output order.
  typedef struct packed {
    logic [1:0] cnt;
    kind_t      k0;
    kind_t      k1;
    kind_t      k2;
    logic [7:0] ch;
  } bundle_t;

endpackage

### rtl/core/csvt_decode.sv
// Combinational decoder: one request plus the parser flags gives next flags and results.
module csvt_decode (
  input  csvt_pkg::pstate_t cur,
  input  logic              filter_comments,
  input  logic              op,
  input  logic [7:0]        byte_req,
  output csvt_pkg::pstate_t nxt,
  output csvt_pkg::bundle_t res
);

  logic q_eff;
  logic hit_quote;

  assign q_eff     = cur.quoted & ~cur.quote_pending;
  assign hit_quote = (byte_req == csvt_pkg::CH_QUOTE);

  always_comb begin
    nxt    = cur;
    res.cnt = 2'd0;
    res.k0  = csvt_pkg::KIND_CHAR;
    res.k1  = csvt_pkg::KIND_CHAR;
    res.k2  = csvt_pkg::KIND_CHAR;
    res.ch  = byte_req;
    if (op == csvt_pkg::OP_FLUSH) begin
      nxt = '0;
      priority if (cur.cell_nonempty) begin
        res.cnt = 2'd3;
        res.k0  = csvt_pkg::KIND_CELL;
        res.k1  = csvt_pkg::KIND_ROW;
        res.k2  = csvt_pkg::KIND_END;
      end else if (cur.row_has_cells) begin
        res.cnt = 2'd2;
        res.k0  = csvt_pkg::KIND_ROW;
        res.k1  = csvt_pkg::KIND_END;
      end else begin
        res.cnt = 2'd1;
        res.k0  = csvt_pkg::KIND_END;
      end
    end else if (cur.in_comment) begin
      if (byte_req == csvt_pkg::CH_NEWLINE) begin
        nxt.in_comment = 1'b0;
      end
    end else begin
      nxt.quote_pending = 1'b0;
      nxt.quoted        = q_eff;
      priority if (cur.quote_pending && hit_quote) begin
        // Doubled quote inside quotes: one literal quote, still quoted.
        nxt.quoted        = cur.quoted;
        nxt.cell_nonempty = 1'b1;
        res.cnt           = 2'd1;
      end else if (filter_comments && (byte_req == csvt_pkg::CH_HASH)) begin
        nxt.in_comment = 1'b1;
      end else if (hit_quote) begin
        if (q_eff) begin
          nxt.quote_pending = 1'b1;
        end else begin
          nxt.quoted = 1'b1;
        end
      end else if (q_eff) begin
        nxt.cell_nonempty = 1'b1;
        res.cnt           = 2'd1;
      end else if (byte_req == csvt_pkg::CH_COMMA) begin
        nxt.cell_nonempty = 1'b0;
        nxt.row_has_cells = 1'b1;
        res.cnt           = 2'd1;
        res.k0            = csvt_pkg::KIND_CELL;
      end else if (byte_req == csvt_pkg::CH_NEWLINE) begin
        nxt.cell_nonempty = 1'b0;
        nxt.row_has_cells = 1'b0;
        if (cur.cell_nonempty) begin
          res.cnt = 2'd2;
          res.k0  = csvt_pkg::KIND_CELL;
          res.k1  = csvt_pkg::KIND_ROW;
        end else begin
          res.cnt = 2'd1;
          res.k0  = csvt_pkg::KIND_ROW;
        end
      end else begin
        nxt.cell_nonempty = 1'b1;
        res.cnt           = 2'd1;
      end
    end
  end

endmodule

### rtl/core/csvt_emit.sv
// Result register: holds one request's results, hands out one per unstalled cycle.
module csvt_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  csvt_pkg::bundle_t bundle,
  input  logic              out_stall,
  output logic              can_load,
  output logic              out_valid,
  output logic [1:0]        kind,
  output logic [7:0]        char_res,
  output logic              last_of_run
);

  logic [1:0]      cnt;
  csvt_pkg::kind_t k0;
  csvt_pkg::kind_t k1;
  csvt_pkg::kind_t k2;
  logic [7:0]      ch;
  logic            pop;

  assign out_valid   = (cnt != 2'd0);
  assign pop         = out_valid & ~out_stall;
  assign can_load    = (cnt == 2'd0) | ((cnt == 2'd1) & ~out_stall);
  assign kind        = k0;
  assign char_res    = (k0 == csvt_pkg::KIND_CHAR) ? ch : 8'd0;
  assign last_of_run = (cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= bundle.cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      k0 <= bundle.k0;
      k1 <= bundle.k1;
      k2 <= bundle.k2;
      ch <= bundle.ch;
    end else if (pop) begin
      k0 <= k1;
      k1 <= k2;
    end
  end

endmodule

### rtl/core/csv_tokenizer.sv
// CSV tokenizer top level: input register, parser flags, decoder, result register, APB register.
// A request is held in the input register and then its results in the result register.
// Throughput: one request per cycle while each request gives at most one result and the
// output does not stall; a request's k results leave the result register one per unstalled cycle.
// Reset (rst, synchronous, active high) clears the parser flags, both valid stages and
// the comment filter register.
module csv_tokenizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic [7:0]                     byte_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     kind,
  output logic [7:0]                     char_res,
  output logic                           last_of_run,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [csvt_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  // The single configuration register. When it is set, a hash byte opens a
  // comment that swallows everything through the next newline.
  logic filter_comments;

  assign pready = 1'b1;
  assign prdata = (paddr == csvt_pkg::REG_FILTER_ADDR) ? {31'd0, filter_comments} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_comments <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == csvt_pkg::REG_FILTER_ADDR)) begin
      filter_comments <= pwdata[0];
    end
  end

  // Input register. A request waits here until the result register can take
  // the whole set of results it produces; the parser flags move at that moment.
  logic       a_valid;
  logic       a_op;
  logic [7:0] a_byte;
  logic       advance;
  logic       can_load;

  assign advance  = a_valid & can_load;
  assign in_stall = a_valid & ~can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_op   <= op;
      a_byte <= byte_req;
    end
  end

  // Parser flags: quoted mode, the one-byte quote lookahead, comment mode and
  // the two emptiness flags that decide whether a newline or a flush closes a
  // cell and a row.
  csvt_pkg::pstate_t st;
  csvt_pkg::pstate_t st_next;
  csvt_pkg::bundle_t bundle;

  csvt_decode u_decode (
    .cur             (st),
    .filter_comments (filter_comments),
    .op              (a_op),
    .byte_req        (a_byte),
    .nxt             (st_next),
    .res             (bundle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register. It can take a new set of results when it is empty or
  // when its last result leaves in this cycle, so a stream of one-result
  // requests flows without a gap. Requests that give no result pass through
  // as an empty set.
  csvt_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .bundle      (bundle),
    .out_stall   (out_stall),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .kind        (kind),
    .char_res    (char_res),
    .last_of_run (last_of_run)
  );

  // The input only stalls while results are still waiting to be taken.
  a_stall_needs_results: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // A pending quote can only exist inside a quoted section.
  a_pending_inside_quotes: assert property (@(posedge clk) disable iff (rst)
    st.quote_pending |-> st.quoted)
    else $error("quote lookahead set outside quotes");

  // After a flush reaches the decoder, the parser starts a fresh stream.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && (a_op == csvt_pkg::OP_FLUSH)) |=> (st == '0))
    else $error("parser flags not cleared by flush");

  // A result that is not the last of its request is followed by another one.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_of_run && !out_stall) |=> out_valid)
    else $error("result run ended early");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the CSV tokenizer: directed cases, random CSV traffic, APB register.
module testbench;

  // One expected tokenizer event, in the order the block must emit it.
  typedef struct {
    csvt_pkg::kind_t kind;
    logic [7:0]      ch;
    logic            last;
  } token_t;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic                           op;
  logic [7:0]                     byte_req;
  logic                           out_valid;
  logic                           out_stall;
  logic [1:0]                     kind;
  logic [7:0]                     char_res;
  logic                           last_of_run;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [csvt_pkg::PADDR_W-1:0]   paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  // Events predicted for accepted requests and not yet seen on the output.
  token_t expected_tokens[$];
  int     mismatch_count = 0;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int     send_gap_pct = 0;
  int     recv_stall_pct = 0;

  // Private copy of the parser flags and the comment filter register.
  logic   filter_on;
  logic   in_quotes;
  logic   quote_seen;
  logic   in_comment_line;
  logic   cell_open;
  logic   row_open;

  csv_tokenizer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .byte_req    (byte_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .char_res    (char_res),
    .last_of_run (last_of_run),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Hard stop in case the block hangs; the slowest legal run is far shorter.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // The receiver decides at each falling edge whether to stall the next edge.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker: every accepted event is matched against the oldest prediction.
  always @(posedge clk) begin
    token_t exp_tok;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected event: kind %0d char %02h last %0b", kind, char_res, last_of_run);
        mismatch_count++;
      end else begin
        exp_tok = expected_tokens.pop_front();
        if (kind !== exp_tok.kind) begin
          $error("kind: expected %0d, got %0d", exp_tok.kind, kind);
          mismatch_count++;
        end
        if (char_res !== exp_tok.ch) begin
          $error("char_res: expected %02h, got %02h", exp_tok.ch, char_res);
          mismatch_count++;
        end
        if (last_of_run !== exp_tok.last) begin
          $error("last_of_run: expected %0b, got %0b", exp_tok.last, last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  function automatic void push_token(csvt_pkg::kind_t k, logic [7:0] c);
    token_t t;
    t.kind = k;
    t.ch   = c;
    t.last = 1'b0;
    expected_tokens = {expected_tokens, t};
  endfunction

  function automatic void clear_parser_flags();
    in_quotes       = 1'b0;
    quote_seen      = 1'b0;
    in_comment_line = 1'b0;
    cell_open       = 1'b0;
    row_open        = 1'b0;
  endfunction

  // Predicts the events of one accepted request and advances the parser flags.
  // The checks run in priority order; the first that claims the byte ends it.
  function automatic void tokenize_request(csvt_pkg::op_t o, logic [7:0] b);
    int  first_new;
    bit  taken;
    first_new = expected_tokens.size();
    taken = 1'b0;
    if (o == csvt_pkg::OP_FLUSH) begin
      // End of input closes an open cell and a row with cells, then ends the stream.
      if (cell_open) begin
        push_token(csvt_pkg::KIND_CELL, 8'h00);
        row_open = 1'b1;
      end
      if (row_open) begin
        push_token(csvt_pkg::KIND_ROW, 8'h00);
      end
      push_token(csvt_pkg::KIND_END, 8'h00);
      clear_parser_flags();
    end else begin
      // A comment swallows everything through its newline, whatever the filter says now.
      if (in_comment_line) begin
        if (b == csvt_pkg::CH_NEWLINE) begin
          in_comment_line = 1'b0;
        end
        taken = 1'b1;
      end
      // A quote inside quotes waits for the next byte: a second quote is a literal one,
      // anything else closes the quoted section and is parsed as unquoted text.
      if (!taken && quote_seen) begin
        quote_seen = 1'b0;
        if (b == csvt_pkg::CH_QUOTE) begin
          cell_open = 1'b1;
          push_token(csvt_pkg::KIND_CHAR, csvt_pkg::CH_QUOTE);
          taken = 1'b1;
        end else begin
          in_quotes = 1'b0;
        end
      end
      if (!taken && filter_on && b == csvt_pkg::CH_HASH) begin
        in_comment_line = 1'b1;
        taken = 1'b1;
      end
      if (!taken && b == csvt_pkg::CH_QUOTE) begin
        if (in_quotes) begin
          quote_seen = 1'b1;
        end else begin
          in_quotes = 1'b1;
        end
        taken = 1'b1;
      end
      if (!taken && in_quotes) begin
        cell_open = 1'b1;
        push_token(csvt_pkg::KIND_CHAR, b);
        taken = 1'b1;
      end
      if (!taken && b == csvt_pkg::CH_COMMA) begin
        cell_open = 1'b0;
        row_open  = 1'b1;
        push_token(csvt_pkg::KIND_CELL, 8'h00);
        taken = 1'b1;
      end
      if (!taken && b == csvt_pkg::CH_NEWLINE) begin
        // An empty trailing cell is not reported, but the row always is.
        if (cell_open) begin
          push_token(csvt_pkg::KIND_CELL, 8'h00);
        end
        push_token(csvt_pkg::KIND_ROW, 8'h00);
        cell_open = 1'b0;
        row_open  = 1'b0;
        taken = 1'b1;
      end
      if (!taken) begin
        cell_open = 1'b1;
        push_token(csvt_pkg::KIND_CHAR, b);
      end
    end
    if (expected_tokens.size() > first_new) begin
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    end
  endfunction

  // Sends one request: optional idle cycles, then valid held until the block takes it.
  task automatic send_request(csvt_pkg::op_t o, logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    byte_req <= b;
    do begin
      @(posedge clk);
    end while (in_stall);
    tokenize_request(o, b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_request(csvt_pkg::OP_BYTE, s[i]);
    end
  endtask

  // Stops sending and waits until every predicted event has come out. Requests
  // without events may still be in flight, so a few more cycles pass after that.
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_write(logic [csvt_pkg::PADDR_W-1:0] a, logic [31:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(logic [csvt_pkg::PADDR_W-1:0] a, output logic [31:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    d = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // The filter register is only touched while the tokenizer is idle.
  task automatic set_comment_filter(logic v);
    logic [31:0] readback;
    wait_until_drained();
    apb_write(csvt_pkg::REG_FILTER_ADDR, {31'h0, v});
    filter_on = v;
    apb_read(csvt_pkg::REG_FILTER_ADDR, readback);
    if (readback[0] !== v) begin
      $error("filter_comments: expected %0b, got %0b", v, readback[0]);
      mismatch_count++;
    end
  endtask

  // Extreme bytes, commas, empty cells, newlines and flushes of empty and open rows.
  task automatic test_plain_cells();
    send_request(csvt_pkg::OP_FLUSH, 8'h00);
    send_request(csvt_pkg::OP_BYTE, 8'h00);
    send_request(csvt_pkg::OP_BYTE, 8'hFF);
    send_text(",,\n");
    send_text("\n");
    send_text("c");
    send_request(csvt_pkg::OP_FLUSH, 8'hFF);
  endtask

  // Doubled quotes, quoted separators, a closing quote followed by text, an empty
  // quoted cell, a hash while the filter is off, and a flush inside open quotes.
  task automatic test_quoting();
    send_text("\"\"\",\n\"b\n");
    send_text("\"\"\n#");
    send_text("\"q");
    send_request(csvt_pkg::OP_FLUSH, 8'h5A);
  endtask

  // Comments: a hash inside quotes, a hash right after a doubled quote, a comment cut
  // short by the end of input, and the filter turned off in the middle of a comment.
  task automatic test_comments();
    set_comment_filter(1'b1);
    send_text("\"#z\n\"\"#y\n");
    send_text("#a");
    send_request(csvt_pkg::OP_FLUSH, 8'h00);
    send_text("#");
    set_comment_filter(1'b0);
    send_text("x\nk\n");
    send_request(csvt_pkg::OP_FLUSH, 8'h00);
  endtask

  function automatic logic [7:0] random_text_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h30, 8'h7A));
    endcase
  endfunction

  // Random CSV: mostly plain and quoted cells and comment lines with random content,
  // with some raw noise bytes and flushes mixed in.
  task automatic test_random_traffic(int gap_pct, int stall_pct, logic filt, int requests);
    int sent;
    int n;
    bit drained;
    set_comment_filter(filt);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    drained = 1'b0;
    while (sent < requests) begin
      // Halfway through, the sender holds off until the output has caught up.
      if (!drained && sent >= requests / 2) begin
        wait_until_drained();
        drained = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          n = $urandom_range(0, 4);
          for (int i = 0; i < n; i++) begin
            send_request(csvt_pkg::OP_BYTE, random_text_byte());
          end
          send_request(csvt_pkg::OP_BYTE, ($urandom_range(0, 2) == 0) ?
                       csvt_pkg::CH_NEWLINE : csvt_pkg::CH_COMMA);
          sent += n + 1;
        end
        3, 4: begin
          n = $urandom_range(0, 4);
          send_request(csvt_pkg::OP_BYTE, csvt_pkg::CH_QUOTE);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
              send_request(csvt_pkg::OP_BYTE, csvt_pkg::CH_QUOTE);
              send_request(csvt_pkg::OP_BYTE, csvt_pkg::CH_QUOTE);
            end else begin
              send_request(csvt_pkg::OP_BYTE, random_text_byte());
            end
          end
          send_request(csvt_pkg::OP_BYTE, csvt_pkg::CH_QUOTE);
          send_request(csvt_pkg::OP_BYTE, ($urandom_range(0, 2) == 0) ?
                       csvt_pkg::CH_NEWLINE : csvt_pkg::CH_COMMA);
          sent += n + 3;
        end
        5: begin
          n = $urandom_range(0, 3);
          send_request(csvt_pkg::OP_BYTE, csvt_pkg::CH_HASH);
          for (int i = 0; i < n; i++) begin
            send_request(csvt_pkg::OP_BYTE, random_text_byte());
          end
          send_request(csvt_pkg::OP_BYTE, csvt_pkg::CH_NEWLINE);
          sent += n + 2;
        end
        6, 7: begin
          send_request(csvt_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
          sent++;
        end
        8: begin
          case ($urandom_range(0, 3))
            0:       send_request(csvt_pkg::OP_BYTE, csvt_pkg::CH_QUOTE);
            1:       send_request(csvt_pkg::OP_BYTE, csvt_pkg::CH_HASH);
            2:       send_request(csvt_pkg::OP_BYTE, csvt_pkg::CH_COMMA);
            default: send_request(csvt_pkg::OP_BYTE, csvt_pkg::CH_NEWLINE);
          endcase
          sent++;
        end
        default: begin
          send_request(csvt_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
          sent++;
        end
      endcase
    end
    send_request(csvt_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    op        = csvt_pkg::OP_BYTE;
    byte_req  = 8'h00;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = 32'h0;
    filter_on = 1'b0;
    clear_parser_flags();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_gap_pct   = 10;
    recv_stall_pct = 30;
    test_plain_cells();
    test_quoting();
    test_comments();
    test_random_traffic(25, 74, 1'b1, 55);
    test_random_traffic(74, 25, 1'b0, 55);
    test_random_traffic(0, 0, 1'b1, 55);
    wait_until_drained();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
